### hdl/lms_pkg.sv
package lms_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int SAMPLE_W    = 16;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS) + 1;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int LINE_W      = 2 * SAMPLE_W;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 40;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

  // Neighbour offsets, clockwise from the upper left.
  localparam int OFF_ROW [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
  localparam int OFF_COL [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [9:0] row_index;
    logic [9:0] column_index;
    sample_t    sample_out;
    logic       is_local_min;
    logic       frame_last;
  } result_t;

  // Control from the read-modify-write stage to the window.
  typedef struct packed {
    logic             step;
    logic             clear;
    logic [9:0]       row_index;
    logic [COL_W-1:0] col;
    logic             flushing;
    logic             up_ok;
    logic             down_ok;
    logic             left0_ok;
    logic             left1_ok;
  } win_ctrl_t;

  // Clamp a register value to 1..hi.
  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

### hdl/lms_line_ram.sv
module lms_line_ram (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [lms_pkg::COL_W-1:0]         rd_addr,
  output logic [lms_pkg::LINE_W-1:0]        rd_data,
  input  logic                              wr_en,
  input  logic [lms_pkg::COL_W-1:0]         wr_addr,
  input  logic [lms_pkg::LINE_W-1:0]        wr_data
);

  // Each entry holds one column of both line buffers: even rows low, odd rows high.
  logic [lms_pkg::LINE_W-1:0] mem [0:lms_pkg::MAX_COLUMNS-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/lms_window.sv
module lms_window (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lms_pkg::win_ctrl_t    ctrl,
  input  lms_pkg::sample_t      top,
  input  lms_pkg::sample_t      mid,
  input  lms_pkg::sample_t      bot,
  output lms_pkg::result_t      res0,
  output lms_pkg::result_t      res1
);

  lms_pkg::sample_t win_r   [0:2][0:2];
  lms_pkg::sample_t win_nxt [0:2][0:2];
  logic             smaller0;
  logic             smaller1;

  always_comb begin
    int  dr;
    int  dc;
    int  wc;
    logic ok;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = top;
    win_nxt[1][2] = mid;
    win_nxt[2][2] = bot;
    smaller0 = 1'b0;
    smaller1 = 1'b0;
    for (int k = 0; k < 8; k++) begin
      dr = lms_pkg::OFF_ROW[k];
      dc = lms_pkg::OFF_COL[k];
      // Inner column: the right neighbour always lies inside the row.
      ok = 1'b1;
      if (dr < 0 && !ctrl.up_ok) ok = 1'b0;
      if (dr > 0 && !ctrl.down_ok) ok = 1'b0;
      if (dc < 0 && !ctrl.left0_ok) ok = 1'b0;
      if (ok && (win_nxt[1 + dr][1 + dc] < win_nxt[1][1])) smaller0 = 1'b1;
      // Last column of the row: no right neighbour.
      ok = 1'b1;
      if (dr < 0 && !ctrl.up_ok) ok = 1'b0;
      if (dr > 0 && !ctrl.down_ok) ok = 1'b0;
      if (dc < 0 && !ctrl.left1_ok) ok = 1'b0;
      if (dc > 0) ok = 1'b0;
      wc = (dc > 0) ? 2 : 2 + dc;
      if (ok && (win_nxt[1 + dr][wc] < win_nxt[1][2])) smaller1 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (ctrl.step) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    res0.row_index    = ctrl.row_index;
    res0.column_index = ctrl.col - lms_pkg::COL_W'(1);
    res0.sample_out   = win_nxt[1][1];
    res0.is_local_min = !smaller0;
    res0.frame_last   = 1'b0;
    res1.row_index    = ctrl.row_index;
    res1.column_index = ctrl.col;
    res1.sample_out   = win_nxt[1][2];
    res1.is_local_min = !smaller1;
    res1.frame_last   = ctrl.flushing;
  end

endmodule

### hdl/lms_result_fifo.sv
module lms_result_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_a,
  input  lms_pkg::result_t            data_a,
  input  logic                        push_b,
  input  lms_pkg::result_t            data_b,
  output logic [lms_pkg::CNT_W-1:0]   free_cnt,
  output logic                        head_valid,
  output lms_pkg::result_t            head,
  input  logic                        pop
);

  lms_pkg::result_t           q_r [0:lms_pkg::FIFO_DEPTH-1];
  logic [lms_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lms_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lms_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [lms_pkg::CNT_W-1:0]  n_push;
  logic                       do_pop;
  lms_pkg::result_t           first;

  assign n_push     = lms_pkg::CNT_W'(push_a) + lms_pkg::CNT_W'(push_b);
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;
  assign free_cnt   = lms_pkg::CNT_W'(lms_pkg::FIFO_DEPTH) - count_r;
  assign first      = push_a ? data_a : data_b;

  assign wr_ptr_nxt = wr_ptr_r + n_push[lms_pkg::PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + lms_pkg::PTR_W'(do_pop);
  assign count_nxt  = count_r + n_push - lms_pkg::CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (n_push != '0) begin
      q_r[wr_ptr_r] <= first;
    end
    if (push_a && push_b) begin
      q_r[wr_ptr_r + lms_pkg::PTR_W'(1)] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    n_push <= free_cnt)
    else $error("result queue pushed beyond its free space");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lms_pkg::CNT_W'(lms_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule

### hdl/local_minimum_3x3_detect.sv
// 3x3 local-minimum detector for a matrix of signed Q8.8 samples in raster order.
// Input words: in_tdata carries the sample, in_tuser the drain flag. After the
// last sample of a frame, one drain word per column flushes the final row; drain
// words that arrive before that are accepted and dropped. Each result word names
// the decided element (row, column, value) and whether no neighbour inside the
// matrix is strictly smaller; out_tlast marks the frame's final element.
// The decision for (r-1,c-1) follows sample (r,c); the word that ends a row
// yields two results (one if the row has one column); row zero yields none.
// Throughput: one input word per cycle while the result queue has room; a taken
// word reads its entry of the line memory (1024 x 32, both line buffers side by
// side) and, outside the flush row, writes it back as it leaves the memory stage.
// A frame of C columns yields C results per row; the queue absorbs the two
// results of a row-ending word, so a receiver that never stalls keeps full rate.
// A four-entry result queue decouples the two sides; when it cannot take the
// results of the word in the memory stage, in_tready falls until it can.
// cfg_we writes row_count (index 0) or column_count (index 1), clamped to
// 1..1024, and restarts the frame; write only while the block is idle.
// Reset sets both counts to 1 and the position to row 0, column 0. Line memory
// contents are not cleared: unwritten entries never reach a result.
module local_minimum_3x3_detect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lms_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] sample_in
  input  logic                              in_tuser,   // [0] drain
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [9:0] row_index, [19:10] column_index, [35:20] sample_out, [36] is_local_min
  output logic [lms_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tlast,  // frame_last
  input  logic                              cfg_we,
  input  logic [lms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lms_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam logic [lms_pkg::CFG_W-1:0] ROWS_HI = lms_pkg::CFG_W'(lms_pkg::MAX_ROWS);
  localparam logic [lms_pkg::CFG_W-1:0] COLS_HI = lms_pkg::CFG_W'(lms_pkg::MAX_COLUMNS);

  logic [lms_pkg::CFG_W-1:0]   rows_r, cols_r;
  logic [lms_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [lms_pkg::COL_W-1:0]   col_r, col_nxt;

  logic                        p_valid_r, p_valid_nxt;
  logic [lms_pkg::ROW_W-1:0]   p_row_r;
  logic [lms_pkg::COL_W-1:0]   p_col_r;
  logic                        p_flush_r;
  logic                        p_last_col_r;
  lms_pkg::sample_t            p_sample_r;

  logic                        lw_valid_r;
  logic [lms_pkg::COL_W-1:0]   lw_addr_r;
  logic [lms_pkg::LINE_W-1:0]  lw_data_r;

  logic                        flushing, last_col, accept, take;
  logic                        emit0, emit1, p_fire, wr_en;
  logic [lms_pkg::CNT_W-1:0]   n_res, free_cnt;
  logic [lms_pkg::LINE_W-1:0]  rd_data, word, wr_data;
  lms_pkg::sample_t            top, mid, bot;
  lms_pkg::win_ctrl_t          wctrl;
  lms_pkg::result_t            res0, res1, head;

  assign flushing = (row_r >= lms_pkg::ROW_W'(rows_r));
  assign last_col = ((lms_pkg::CFG_W'(col_r) + lms_pkg::CFG_W'(1)) == cols_r);
  assign accept   = in_tvalid && in_tready;
  // An early drain word is consumed without effect.
  assign take     = accept && (flushing || !in_tuser);

  assign emit0  = p_valid_r && (p_row_r != '0) && (p_col_r != '0);
  assign emit1  = p_valid_r && (p_row_r != '0) && p_last_col_r;
  assign n_res  = lms_pkg::CNT_W'(emit0) + lms_pkg::CNT_W'(emit1);
  assign p_fire = p_valid_r && (free_cnt >= n_res);

  assign in_tready = !p_valid_r || p_fire;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (take) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = flushing ? '0 : row_r + lms_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + lms_pkg::COL_W'(1);
      end
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (take) p_valid_nxt = 1'b1;
    else if (p_fire) p_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= lms_pkg::CFG_W'(1);
      cols_r    <= lms_pkg::CFG_W'(1);
      row_r     <= '0;
      col_r     <= '0;
      p_valid_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == lms_pkg::REG_ROW_COUNT) begin
        rows_r <= lms_pkg::clamp_cfg(cfg_wdata, ROWS_HI);
      end
      if (cfg_index == lms_pkg::REG_COLUMN_COUNT) begin
        cols_r <= lms_pkg::clamp_cfg(cfg_wdata, COLS_HI);
      end
      row_r     <= '0;
      col_r     <= '0;
      p_valid_r <= 1'b0;
    end else begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_row_r      <= row_r;
      p_col_r      <= col_r;
      p_flush_r    <= flushing;
      p_last_col_r <= last_col;
      p_sample_r   <= in_tdata;
    end
  end

  lms_line_ram u_ram (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (p_col_r),
    .wr_data (wr_data)
  );

  // The last write-back is forwarded: with a single column the next word reads
  // the entry in the same cycle as it is written.
  assign word = (lw_valid_r && (lw_addr_r == p_col_r)) ? lw_data_r : rd_data;

  always_comb begin
    if (p_row_r[0]) begin
      top     = word[lms_pkg::LINE_W-1:lms_pkg::SAMPLE_W];
      mid     = word[lms_pkg::SAMPLE_W-1:0];
      wr_data = {p_sample_r, word[lms_pkg::SAMPLE_W-1:0]};
    end else begin
      top     = word[lms_pkg::SAMPLE_W-1:0];
      mid     = word[lms_pkg::LINE_W-1:lms_pkg::SAMPLE_W];
      wr_data = {word[lms_pkg::LINE_W-1:lms_pkg::SAMPLE_W], p_sample_r};
    end
  end

  assign bot   = p_flush_r ? '0 : p_sample_r;
  assign wr_en = p_fire && !p_flush_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (wr_en) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr_r <= p_col_r;
      lw_data_r <= wr_data;
    end
  end

  always_comb begin
    wctrl.step      = p_fire;
    wctrl.clear     = cfg_we;
    wctrl.row_index = p_row_r[9:0] - 10'd1;
    wctrl.col       = p_col_r;
    wctrl.flushing  = p_flush_r;
    wctrl.up_ok     = (p_row_r >= lms_pkg::ROW_W'(2));
    wctrl.down_ok   = !p_flush_r;
    wctrl.left0_ok  = (p_col_r >= lms_pkg::COL_W'(2));
    wctrl.left1_ok  = (p_col_r != '0);
  end

  lms_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (wctrl),
    .top   (top),
    .mid   (mid),
    .bot   (bot),
    .res0  (res0),
    .res1  (res1)
  );

  lms_result_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_a     (p_fire && emit0),
    .data_a     (res0),
    .push_b     (p_fire && emit1),
    .data_b     (res1),
    .free_cnt   (free_cnt),
    .head_valid (out_tvalid),
    .head       (head),
    .pop        (out_tready)
  );

  assign out_tdata = {3'b000, head.is_local_min, head.sample_out,
                      head.column_index, head.row_index};
  assign out_tlast = head.frame_last;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    lms_pkg::CFG_W'(col_r) < cols_r)
    else $error("column position beyond the row");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lms_pkg::CFG_W'(row_r) <= rows_r)
    else $error("row position beyond the flush row");

  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    take && !cfg_we |=> p_valid_r)
    else $error("taken word did not reach the memory stage");

  a_flush_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r && p_flush_r |-> !wr_en)
    else $error("line memory written during the flush row");

endmodule
